// ----- rtl/core/shm_pkg.sv -----
package shm_pkg;

  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_W     = $clog2(PHASE_COUNT);
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned FIELD_W     = 16;
  localparam logic [FIELD_W-1:0] DELAY_RESET = FIELD_W'(2);

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_START       = 3'd1,
    MODE_ENABLE      = 3'd2,
    MODE_DISABLE     = 3'd3,
    MODE_SET_ABORT   = 3'd4,
    MODE_CLEAR_ABORT = 3'd5
  } shm_mode_e;

  typedef logic [PHASE_W-1:0] phase_t;

  // Control flags of the sequencer, passed between the state registers and the update logic.
  typedef struct packed {
    phase_t phase;
    logic   drive_en;
    logic   moving;
    logic   move_dir;
    logic   abort;
  } shm_flags_t;

  typedef struct packed {
    logic [3:0] coils;
    phase_t     phase;
    logic       busy;
    logic       aborted;
    logic       enabled;
  } shm_result_t;

  // Half-step coil pattern, bit0 is the first coil.
  function automatic logic [3:0] coil_pattern(input phase_t ph);
    logic [3:0] pat;
    unique case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/shm_update.sv -----
module shm_update import shm_pkg::*; #(
  parameter int unsigned CountBits = COUNT_BITS
) (
  input  logic [2:0]           mode_i,
  input  logic [FIELD_W-1:0]   step_count_i,
  input  logic                 direction_i,
  input  logic [FIELD_W-1:0]   step_delay_i,
  input  shm_flags_t           flags_i,
  input  logic [CountBits-1:0] steps_left_i,
  input  logic [CountBits-1:0] delay_left_i,
  output shm_flags_t           flags_o,
  output logic [CountBits-1:0] steps_left_o,
  output logic [CountBits-1:0] delay_left_o
);

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  logic [CountBits-1:0] count_sat;
  logic [CountBits-1:0] delay_sat;
  logic [CountBits-1:0] delay_dec;
  shm_mode_e            mode;

  // Fit the 16-bit fields into the counter width, saturating when narrower.
  if (CountBits >= FIELD_W) begin : g_wide
    assign count_sat = CountBits'(step_count_i);
    assign delay_sat = CountBits'(step_delay_i);
  end else begin : g_narrow
    assign count_sat = (step_count_i[FIELD_W-1:CountBits] != '0) ? CountMax
                                                                 : step_count_i[CountBits-1:0];
    assign delay_sat = (step_delay_i[FIELD_W-1:CountBits] != '0) ? CountMax
                                                                 : step_delay_i[CountBits-1:0];
  end

  assign mode      = shm_mode_e'(mode_i);
  assign delay_dec = (delay_left_i != '0) ? delay_left_i - 1'b1 : delay_left_i;

  always_comb begin
    flags_o      = flags_i;
    steps_left_o = steps_left_i;
    delay_left_o = delay_left_i;
    unique case (mode)
      MODE_TICK: begin
        if (flags_i.moving) begin
          delay_left_o = delay_dec;
          if (delay_dec == '0) begin
            if (steps_left_i != '0) begin
              flags_o.phase = flags_i.move_dir ? flags_i.phase - 1'b1 : flags_i.phase + 1'b1;
              delay_left_o  = delay_sat;
              steps_left_o  = steps_left_i - 1'b1;
            end else begin
              flags_o.moving = 1'b0;
            end
          end
        end
      end
      MODE_START: begin
        if (flags_i.drive_en && !flags_i.abort) begin
          flags_o.moving = 1'b0;
          steps_left_o   = '0;
          delay_left_o   = '0;
          if (count_sat != '0) begin
            flags_o.move_dir = direction_i;
            flags_o.phase    = direction_i ? flags_i.phase - 1'b1 : flags_i.phase + 1'b1;
            delay_left_o     = delay_sat;
            steps_left_o     = count_sat - 1'b1;
            flags_o.moving   = (count_sat != CountBits'(1)) || (delay_sat != '0);
          end
        end
      end
      MODE_ENABLE: begin
        flags_o.drive_en = 1'b1;
      end
      MODE_DISABLE: begin
        flags_o.drive_en = 1'b0;
        flags_o.moving   = 1'b0;
        steps_left_o     = '0;
        delay_left_o     = '0;
      end
      MODE_SET_ABORT: begin
        flags_o.abort  = 1'b1;
        flags_o.moving = 1'b0;
        steps_left_o   = '0;
        delay_left_o   = '0;
      end
      MODE_CLEAR_ABORT: begin
        flags_o.abort = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/stepper_half_step_mover.sv -----
// Output: an accepted transaction's result is registered in out_q, or in the
// skid entry when out_q is stalled. Throughput: one transaction per cycle while
// in_ready_o is high; the state update and the result load happen at the
// same edge, and the two-entry output stage drops in_ready_o only when full.
// Reset: coils enabled at phase 0, no move, abort clear, delay register 2.
module stepper_half_step_mover import shm_pkg::*; #(
  parameter int unsigned CountBits = COUNT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [15:0]        step_count_i,
  input  logic               direction_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         coils_o,
  output logic [2:0]         phase_o,
  output logic               busy_res_o,
  output logic               aborted_o,
  output logic               enabled_out_o
);

  logic [FIELD_W-1:0]   step_delay_q;
  shm_flags_t           flags_q, flags_d;
  logic [CountBits-1:0] steps_left_q, steps_left_d;
  logic [CountBits-1:0] delay_left_q, delay_left_d;
  shm_result_t          res_d, out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;
  logic                 in_fire, out_fire;

  shm_update #(.CountBits(CountBits)) u_update (
    .mode_i       (mode_i),
    .step_count_i (step_count_i),
    .direction_i  (direction_i),
    .step_delay_i (step_delay_q),
    .flags_i      (flags_q),
    .steps_left_i (steps_left_q),
    .delay_left_i (delay_left_q),
    .flags_o      (flags_d),
    .steps_left_o (steps_left_d),
    .delay_left_o (delay_left_d)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    res_d.coils   = flags_d.drive_en ? coil_pattern(flags_d.phase) : 4'h0;
    res_d.phase   = flags_d.phase;
    res_d.busy    = flags_d.moving;
    res_d.aborted = flags_d.abort;
    res_d.enabled = flags_d.drive_en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q <= DELAY_RESET;
      flags_q      <= '{phase: '0, drive_en: 1'b1, moving: 1'b0, move_dir: 1'b0, abort: 1'b0};
      steps_left_q <= '0;
      delay_left_q <= '0;
    end else begin
      if (cfg_we_i) begin
        step_delay_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        flags_q      <= flags_d;
        steps_left_q <= steps_left_d;
        delay_left_q <= delay_left_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coils_o       = out_q.coils;
  assign phase_o       = out_q.phase;
  assign busy_res_o    = out_q.busy;
  assign aborted_o     = out_q.aborted;
  assign enabled_out_o = out_q.enabled;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q.moving |-> (steps_left_q == '0) && (delay_left_q == '0))
    else $error("counters pending while no move is active");

  a_abort_stops_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.abort |-> !flags_q.moving)
    else $error("move active while abort flag is set");

  a_disabled_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.enabled) |-> (out_q.coils == 4'h0))
    else $error("coils driven while disabled");

endmodule
